### hw/rtl/gfla_pkg.sv
// ----------------------------------------------------------------------------
// gfla_pkg
// Shared types, codes and constants for the growing free-list allocator.
// ----------------------------------------------------------------------------
package gfla_pkg;

  localparam int POOL_ENTRIES_DEF = 1024;
  localparam int CAP_W            = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd8;

  localparam int IDX_W    = 10;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam logic OP_RESERVE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_RESERVED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LINK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic restart;
    logic accept;
    logic grow;
    logic pop_fresh;
    logic link_rd;
    logic pop_link;
    logic rel;
    logic exhaust;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_rel;
    logic head_valid;
    logic head_fresh;
    logic grow_room;
  } dp_sts_t;

endpackage

### hw/rtl/gfla_ctrl.sv
// ----------------------------------------------------------------------------
// gfla_ctrl
// Sequencer that steps one item through execute, link read and emit.
// ----------------------------------------------------------------------------
module gfla_ctrl
  import gfla_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  dp_sts_t    sts,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    cfg_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready    = 1'b1;
        cfg_ready   = 1'b1;
        cmd.restart = cfg_valid;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.op_rel) begin
          cmd.rel    = 1'b1;
          state_next = S_EMIT;
        end else if (sts.head_valid) begin
          if (sts.head_fresh) begin
            cmd.pop_fresh = 1'b1;
            state_next    = S_EMIT;
          end else begin
            cmd.link_rd = 1'b1;
            state_next  = S_LINK;
          end
        end else if (sts.grow_room) begin
          cmd.grow = 1'b1;
        end else begin
          cmd.exhaust = 1'b1;
          state_next  = S_EMIT;
        end
      end
      S_LINK: begin
        cmd.pop_link = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    m_tvalid_next = cmd.load_out | (m_tvalid & ~m_tready);
  end

`ifndef ASSERT_OFF
  a_link_after_exec: assert property (@(posedge clk) disable iff (rst)
    state == S_LINK |-> $past(state == S_EXEC))
    else $error("link read stage entered from a state other than execute");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_EXEC)
    else $error("accepted item did not move to execute");

  a_load_only_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while still held");
`endif

endmodule

### hw/rtl/gfla_datapath.sv
// ----------------------------------------------------------------------------
// gfla_datapath
// Free-list head, fresh cursor, region extent, link store and result register.
// ----------------------------------------------------------------------------
module gfla_datapath
  import gfla_pkg::*;
#(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_cmd_t              cmd,
  output dp_sts_t                sts,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tuser,
  input  logic [CAP_W-1:0]       cfg_data,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [STATUS_W-1:0]    m_tuser
);

  localparam int IW = $clog2(POOL_ENTRIES);
  localparam int CW = $clog2(POOL_ENTRIES + 1);
  localparam logic [CW-1:0] POOL_LIMIT = CW'(POOL_ENTRIES);

  logic [IW-1:0]        head;
  logic                 head_valid;
  logic [CW-1:0]        cursor;
  logic [CW-1:0]        extent;
  logic                 op_reg;
  logic [IDX_W-1:0]     idx_reg;
  logic [CW-1:0]        link_rdata;
  logic [STATUS_W-1:0]  res_status;
  logic [IW-1:0]        res_granted;
  logic [CW-1:0]        link_mem [POOL_ENTRIES];

  logic [CW-1:0]        cap_clamped;
  logic                 idx_ok;
  logic [CW:0]          grow_sum;
  logic [CW-1:0]        grow_extent;
  logic [CW-1:0]        cursor_inc;
  logic [CW-1:0]        link_wdata;

  always_comb begin
    if (cfg_data == '0) begin
      cap_clamped = CW'(1);
    end else if (32'(cfg_data) > 32'(POOL_ENTRIES)) begin
      cap_clamped = POOL_LIMIT;
    end else begin
      cap_clamped = CW'(cfg_data);
    end
    idx_ok      = 32'(idx_reg) < 32'(POOL_ENTRIES);
    grow_sum    = (CW+1)'(extent) + (((CW+1)'(extent) + (CW+1)'(1)) >> 1);
    grow_extent = (grow_sum > (CW+1)'(POOL_ENTRIES)) ? POOL_LIMIT : grow_sum[CW-1:0];
    cursor_inc  = cursor + CW'(1);
    link_wdata  = head_valid ? CW'(head) : POOL_LIMIT;
  end

  assign sts.op_rel     = (op_reg == OP_RELEASE);
  assign sts.head_valid = head_valid;
  assign sts.head_fresh = (CW'(head) == cursor);
  assign sts.grow_room  = (extent < POOL_LIMIT);

  // Restart uses the freshly written capacity, so it clamps the port value.
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      head_valid <= 1'b1;
      cursor     <= '0;
      extent     <= (32'(CAP_RESET) > 32'(POOL_ENTRIES)) ? POOL_LIMIT : CW'(CAP_RESET);
    end else if (cmd.restart) begin
      head       <= '0;
      head_valid <= 1'b1;
      cursor     <= '0;
      extent     <= cap_clamped;
    end else if (cmd.grow) begin
      cursor     <= extent;
      head       <= IW'(extent);
      head_valid <= 1'b1;
      extent     <= grow_extent;
    end else if (cmd.pop_fresh) begin
      cursor <= cursor_inc;
      if (cursor_inc < extent) begin
        head <= IW'(cursor_inc);
      end else begin
        head_valid <= 1'b0;
        head       <= '0;
      end
    end else if (cmd.pop_link) begin
      if (link_rdata < POOL_LIMIT) begin
        head <= IW'(link_rdata);
      end else begin
        head_valid <= 1'b0;
        head       <= '0;
      end
    end else if (cmd.rel && idx_ok) begin
      head       <= IW'(idx_reg);
      head_valid <= 1'b1;
    end else if (cmd.exhaust) begin
      head_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rel && idx_ok) begin
      link_mem[IW'(idx_reg)] <= link_wdata;
    end
    if (cmd.link_rd) begin
      link_rdata <= link_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_reg  <= s_tuser;
      idx_reg <= s_tdata[IDX_W-1:0];
    end
    if (cmd.rel) begin
      res_status  <= ST_RELEASED;
      res_granted <= '0;
    end else if (cmd.exhaust) begin
      res_status  <= ST_EXHAUSTED;
      res_granted <= '0;
    end else if (cmd.pop_fresh || cmd.link_rd) begin
      res_status  <= ST_RESERVED;
      res_granted <= head;
    end
    if (cmd.load_out) begin
      m_tuser <= res_status;
      m_tdata <= {{(OUT_TDATA_W - IDX_W - COUNT_W){1'b0}},
                  COUNT_W'(extent), IDX_W'(res_granted)};
    end
  end

`ifndef ASSERT_OFF
  a_extent_range: assert property (@(posedge clk) disable iff (rst)
    extent >= CW'(1) && extent <= POOL_LIMIT)
    else $error("region extent outside one to pool size");

  a_release_sets_head: assert property (@(posedge clk) disable iff (rst)
    cmd.rel && idx_ok && !cmd.restart |=> head_valid && head == $past(IW'(idx_reg)))
    else $error("released node did not become the list head");

  a_grow_moves_cursor: assert property (@(posedge clk) disable iff (rst)
    cmd.grow && !cmd.restart |=> head_valid && cursor == $past(extent)
                                 && extent > $past(extent))
    else $error("growth did not open a fresh region at the old extent");
`endif

endmodule

### hw/rtl/growing_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// growing_free_list_allocator_unit
// Node allocator over a linked free list whose region grows on demand.
//
//   channel  signals                      item contents (lowest bit first)
//   s_       s_tvalid s_tready            tuser: operation
//            s_tdata s_tuser              tdata: node_index
//   m_       m_tvalid m_tready            tuser: status
//            m_tdata m_tuser              tdata: granted_index, reserved_count
//   cfg_     cfg_valid cfg_ready cfg_data data: initial_capacity
//
// A release or a reserve served from a fresh node passes through execute
// and emit; a reserve that follows a released link also passes through link
// read, which is registered. A reserve that grows the region repeats execute.
// Reset is synchronous and needs no clearing pass; the link store is read
// only at entries written by a release. A stalled result holds in the output
// register while the next item is accepted; it then waits to be emitted.
// ----------------------------------------------------------------------------
module growing_free_list_allocator_unit
  import gfla_pkg::*;
#(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // node_index
  input  logic                   s_tuser,   // operation
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // granted_index, reserved_count
  output logic [STATUS_W-1:0]    m_tuser,   // status
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CAP_W-1:0]       cfg_data   // initial_capacity
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  gfla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gfla_datapath #(
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_data (cfg_data),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### bench/gfla_alloc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gfla_alloc_checker
// Watches the request, result and capacity channels of the allocator. For
// every accepted request it computes the expected grant, status and region
// size, and it compares each accepted result with the oldest expectation.
// ----------------------------------------------------------------------------
module gfla_alloc_checker
  import gfla_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // node_index
  input  logic                   s_tuser,   // operation
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,   // granted_index, reserved_count
  input  logic [STATUS_W-1:0]    m_tuser,   // status
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CAP_W-1:0]       cfg_data,  // initial_capacity
  output int                     failures,
  output int                     pending
);

  localparam int POOL = POOL_ENTRIES_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    granted;
    logic [COUNT_W-1:0]  count;
  } alloc_result_t;

  alloc_result_t expected_grants[$];
  alloc_result_t want;
  alloc_result_t got;

  logic [CAP_W-1:0]   capacity;
  logic [COUNT_W-1:0] head_node;
  logic               head_ok;
  logic [COUNT_W-1:0] cursor;
  logic [COUNT_W-1:0] extent;
  logic [COUNT_W-1:0] next_link [POOL];

  function automatic logic [COUNT_W-1:0] clamped_capacity(input logic [CAP_W-1:0] v);
    if (v == 0) return COUNT_W'(1);
    if (v > POOL) return COUNT_W'(POOL);
    return COUNT_W'(v);
  endfunction

  task automatic restart_pool();
    head_node = '0;
    head_ok   = 1'b1;
    cursor    = '0;
    extent    = clamped_capacity(capacity);
  endtask

  task automatic predict_alloc(input logic op, input logic [IDX_W-1:0] idx,
                               output alloc_result_t r);
    logic [COUNT_W-1:0] grown;
    logic [COUNT_W-1:0] succ;
    r = '0;
    if (op == OP_RELEASE) begin
      r.status = ST_RELEASED;
      next_link[idx] = head_ok ? head_node : COUNT_W'(POOL);
      head_node = COUNT_W'(idx);
      head_ok = 1'b1;
    end else begin
      if (!head_ok && extent < POOL) begin
        grown = extent + ((extent + COUNT_W'(1)) >> 1);
        if (grown > POOL) grown = COUNT_W'(POOL);
        cursor = extent;
        head_node = extent;
        head_ok = 1'b1;
        extent = grown;
      end
      if (head_ok && head_node < POOL) begin
        r.status = ST_RESERVED;
        r.granted = head_node[IDX_W-1:0];
        if (head_node == cursor) begin
          cursor = cursor + COUNT_W'(1);
          if (cursor < extent) begin
            head_node = cursor;
          end else begin
            head_ok = 1'b0;
            head_node = '0;
          end
        end else begin
          succ = next_link[head_node[IDX_W-1:0]];
          if (succ < POOL) begin
            head_node = succ;
          end else begin
            head_ok = 1'b0;
            head_node = '0;
          end
        end
      end else begin
        r.status = ST_EXHAUSTED;
        head_ok = 1'b0;
      end
    end
    r.count = extent;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      capacity = CAP_RESET;
      restart_pool();
      expected_grants.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.status  = m_tuser;
        got.granted = m_tdata[IDX_W-1:0];
        got.count   = m_tdata[IDX_W +: COUNT_W];
        if (expected_grants.size() == 0) begin
          failures++;
          $display("%0t: unexpected result, status %0d index %0d count %0d",
                   $time, got.status, got.granted, got.count);
        end else begin
          want = expected_grants.pop_front();
          if (want != got) begin
            failures++;
            $display("%0t: status exp %0d got %0d, index exp %0d got %0d, count exp %0d got %0d",
                     $time, want.status, got.status, want.granted, got.granted,
                     want.count, got.count);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        capacity = cfg_data;
        restart_pool();
      end
      if (s_tvalid && s_tready) begin
        predict_alloc(s_tuser, s_tdata[IDX_W-1:0], want);
        expected_grants.push_back(want);
      end
    end
    pending = expected_grants.size();
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives reserve and release requests into the allocator under several
// capacity settings, with bursty requests and a stalling result consumer;
// the checker module judges every result.
// ----------------------------------------------------------------------------
module tb_top
  import gfla_pkg::*;
;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // node_index
  logic                   s_tuser;   // operation
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // granted_index, reserved_count
  logic [STATUS_W-1:0]    m_tuser;   // status
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CAP_W-1:0]       cfg_data;  // initial_capacity

  int failures;
  int pending;
  int hold_trigger;
  int burst_left;
  int idle_cycles;
  logic [IDX_W-1:0] held_nodes[$];

  growing_free_list_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  gfla_alloc_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready && m_tuser == ST_RESERVED) begin
      held_nodes.push_back(m_tdata[IDX_W-1:0]);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : result_consumer
    int mode;
    int span;
    int seen;
    m_tready = 1'b0;
    seen = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 80);
      repeat (span) begin
        @(negedge clk);
        if (hold_trigger != seen) begin
          seen = hold_trigger;
          m_tready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        case (mode)
          0: m_tready = 1'b1;
          1: m_tready = ($urandom_range(0, 1) == 1);
          2: m_tready = ($urandom_range(0, 3) != 0);
          default: m_tready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic send_op(input logic op, input logic [IDX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    s_tvalid = 1'b1;
    s_tdata = IN_TDATA_W'(idx);
    s_tuser = op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    drain();
    cfg_valid = 1'b1;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    held_nodes.delete();
  endtask

  // Most releases return a node that is currently handed out; the rest
  // free arbitrary indices, which the block accepts without checking that they are held.
  task automatic run_phase(input int n, input int reserve_pct);
    int roll;
    int k;
    logic [IDX_W-1:0] idx;
    repeat (n) begin
      roll = $urandom_range(1, 100);
      if (roll <= reserve_pct) begin
        send_op(OP_RESERVE, IDX_W'($urandom));
      end else if (roll <= reserve_pct + (100 - reserve_pct) * 3 / 4 &&
                   held_nodes.size() > 0) begin
        k = $urandom_range(0, held_nodes.size() - 1);
        idx = held_nodes[k];
        held_nodes.delete(k);
        send_op(OP_RELEASE, idx);
      end else begin
        send_op(OP_RELEASE, IDX_W'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_RESERVE;
    cfg_valid = 1'b0;
    cfg_data = '0;
    hold_trigger = 0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    repeat (3) send_op(OP_RESERVE, '0);
    send_op(OP_RELEASE, 10'h3FF);
    send_op(OP_RELEASE, 10'h000);
    send_op(OP_RELEASE, 10'h2AA);
    send_op(OP_RELEASE, 10'h155);
    repeat (12) send_op(OP_RESERVE, 10'h3FF);

    write_capacity(11'd0);
    repeat (3) send_op(OP_RESERVE, '0);
    send_op(OP_RELEASE, 10'd2);
    repeat (2) send_op(OP_RESERVE, '0);

    write_capacity(11'd1024);
    hold_trigger++;
    run_phase(130, 90);

    write_capacity(11'h7FF);
    hold_trigger++;
    run_phase(50, 55);

    write_capacity(11'd1025);
    run_phase(40, 55);

    write_capacity(11'd1);
    run_phase(60, 60);

    write_capacity(CAP_W'($urandom_range(2, 64)));
    run_phase(50, 55);

    write_capacity(11'd3);
    run_phase(50, 50);

    write_capacity(11'd8);
    run_phase(45, 55);

    drain();
    repeat (20) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/gfla_pkg.sv
hw/rtl/gfla_ctrl.sv
hw/rtl/gfla_datapath.sv
hw/rtl/growing_free_list_allocator_unit.sv
bench/gfla_alloc_checker.sv
bench/tb_top.sv
